[hw/rtl/arpc_pkg.sv]
// ----------------------------------------------------------------------------
// ARP cache package
// Types and codes shared by the ARP cache channels and logic.
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int IP_W     = 32;
	localparam int MAC_W    = 48;
	localparam int OPCODE_W = 16;
	localparam int STATUS_W = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// Register indexes of the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_OWN_IP     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_IP = 1'b1;

	// Item kinds and ARP opcodes.
	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_PACKET = 1'b1;
	localparam logic [OPCODE_W-1:0] OP_REQUEST = 16'd1;
	localparam logic [OPCODE_W-1:0] OP_REPLY   = 16'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT      = 3'd0,
		ST_MISS     = 3'd1,
		ST_REPLY    = 3'd2,
		ST_NOT_OURS = 3'd3,
		ST_STORED   = 3'd4,
		ST_UNKNOWN  = 3'd5
	} status_t;

	typedef struct packed {
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} entry_t;

endpackage

[hw/rtl/arpc_if.sv]
// ----------------------------------------------------------------------------
// ARP cache channels
// Valid/ready channels for configuration, items and results.
// ----------------------------------------------------------------------------
interface arpc_cfg_if import arpc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

interface arpc_req_if import arpc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [OPCODE_W-1:0] opcode;
	logic [IP_W-1:0]     peer_ip;
	logic [MAC_W-1:0]    peer_mac;
	logic [IP_W-1:0]     target_ip;

	modport source (output valid, req_type, opcode, peer_ip, peer_mac, target_ip,
		input ready);
	modport sink   (input valid, req_type, opcode, peer_ip, peer_mac, target_ip,
		output ready);
endinterface

interface arpc_rsp_if import arpc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [MAC_W-1:0]    found_mac;
	logic [MAC_W-1:0]    gateway_mac_out;

	modport source (output valid, status, found_mac, gateway_mac_out, input ready);
	modport sink   (input valid, status, found_mac, gateway_mac_out, output ready);
endinterface

[hw/rtl/arpc_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/arp_cache_responder.sv]
// ----------------------------------------------------------------------------
// ARP cache responder
// Learned address table with lookup, request check and reply learning.
// ----------------------------------------------------------------------------
// Usage:
// Configuration words on cfg set own_ip (index 0) and gateway_ip (index 1);
// cfg is always ready. Each word on req gives exactly one word on rsp.
// A lookup word scans the table from entry 0 through one RAM read port,
// one entry per cycle, and stops at the first matching address. It answers
// with a hit there, or with a miss after the last entry below the count;
// an empty table gives a miss without a scan.
// Packet words (request check, reply learning, unknown opcode) need no scan;
// a reply writes its entry at the ring write pointer when it is taken.
// Results sit in an output register; req is ready when idle and that register
// is free or being emptied, so a stalled rsp stalls req after one word.
// Reset clears the write pointer, the entry count, the gateway MAC and the
// configuration; table contents are not cleared, and only entries below
// the count are ever searched.
// ----------------------------------------------------------------------------
module arp_cache_responder import arpc_pkg::*; #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic      clk,
	input  logic      arst_n,
	arpc_cfg_if.sink  cfg,
	arpc_req_if.sink  req,
	arpc_rsp_if.source rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t            state_q;
	logic [IP_W-1:0]   own_ip_q;
	logic [IP_W-1:0]   gateway_ip_q;
	logic [MAC_W-1:0]  gateway_mac_q;
	logic [AW-1:0]     write_ptr_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     idx_q;
	logic [IP_W-1:0]   look_ip_q;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [MAC_W-1:0]    rsp_found_q;
	logic [MAC_W-1:0]    rsp_gw_q;

	logic    req_fire;
	logic    rsp_free;
	logic    rsp_load;
	logic    ram_we;
	logic [AW-1:0] ram_raddr;
	entry_t  ram_wdata;
	entry_t  ram_rdata;
	logic    scan_hit;
	logic    scan_last;

	assign cfg.ready = 1'b1;

	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && rsp_free;
	assign req_fire  = req.valid && req.ready;

	// A result is ready now unless a lookup has entries left to scan.
	assign rsp_load = (state_q == S_IDLE) ?
		(req_fire && !((req.req_type == REQ_LOOKUP) && (count_q != '0))) :
		(scan_hit || scan_last);

	assign ram_we        = req_fire && (req.req_type == REQ_PACKET) && (req.opcode == OP_REPLY);
	assign ram_wdata.ip  = req.peer_ip;
	assign ram_wdata.mac = req.peer_mac;

	// In the scan the read data belongs to idx_q; the next address is fetched meanwhile.
	assign ram_raddr = (state_q == S_SCAN) ? AW'(idx_q + AW'(1)) : '0;
	assign scan_hit  = (ram_rdata.ip == look_ip_q);
	assign scan_last = ((CW'(idx_q) + CW'(1)) == count_q);

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.found_mac       = rsp_found_q;
	assign rsp.gateway_mac_out = rsp_gw_q;

	arpc_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(write_ptr_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q     <= '0;
			gateway_ip_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_OWN_IP:     own_ip_q     <= cfg.data;
				REG_GATEWAY_IP: gateway_ip_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			rsp_valid_q   <= 1'b0;
			gateway_mac_q <= '0;
			write_ptr_q   <= '0;
			count_q       <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (req.req_type == REQ_LOOKUP) begin
							if (count_q != '0) begin
								state_q <= S_SCAN;
							end
						end else if (ram_we) begin
							write_ptr_q <= (write_ptr_q == AW'(TABLE_DEPTH - 1)) ?
								'0 : AW'(write_ptr_q + AW'(1));
							if (count_q != CW'(TABLE_DEPTH)) begin
								count_q <= CW'(count_q + CW'(1));
							end
							if (req.peer_ip == gateway_ip_q) begin
								gateway_mac_q <= req.peer_mac;
							end
						end
					end
				end
				S_SCAN: begin
					if (scan_hit || scan_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers: no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			idx_q <= '0;
			if (req_fire) begin
				look_ip_q   <= req.peer_ip;
				rsp_found_q <= '0;
				rsp_gw_q    <= (ram_we && (req.peer_ip == gateway_ip_q)) ?
					req.peer_mac : gateway_mac_q;
				if (req.req_type == REQ_LOOKUP) begin
					rsp_status_q <= ST_MISS;
				end else begin
					priority if (req.opcode == OP_REQUEST) begin
						rsp_status_q <= (req.target_ip == own_ip_q) ? ST_REPLY : ST_NOT_OURS;
					end else if (req.opcode == OP_REPLY) begin
						rsp_status_q <= ST_STORED;
					end else begin
						rsp_status_q <= ST_UNKNOWN;
					end
				end
			end
		end else begin
			idx_q <= AW'(idx_q + AW'(1));
			if (scan_hit) begin
				rsp_status_q <= ST_HIT;
				rsp_found_q  <= ram_rdata.mac;
			end else begin
				rsp_status_q <= ST_MISS;
				rsp_found_q  <= '0;
			end
		end
	end

endmodule
